[src/spnr_pkg.sv]
// Package for the security chip command port: mode, command and sequence codes,
// latch constants and the BCD helper.
// No dependencies.
package spnr_pkg;

    localparam int SPNR_NVRAM_DEPTH = 256;
    localparam int SPNR_REPLY_DEPTH = 16;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;
    localparam logic [1:0] MODE_BOTH   = 2'd3;

    localparam logic [3:0] CMD_REPLY    = 4'd0;
    localparam logic [3:0] CMD_SERIAL   = 4'd1;
    localparam logic [3:0] CMD_CLOCK    = 4'd3;
    localparam logic [3:0] CMD_NV_WRITE = 4'd5;
    localparam logic [3:0] CMD_NV_READ  = 4'd6;

    localparam logic [0:0] CFG_SERIAL_LOW  = 1'd0;
    localparam logic [0:0] CFG_SERIAL_HIGH = 1'd1;

    localparam logic [10:0] LATCH_WRITE = 11'h480;
    localparam logic [10:0] LATCH_REPLY = 11'h400;
    localparam logic [10:0] LATCH_TICK  = 11'h100;

    localparam logic [7:0] YEAR_BASE   = 8'd94;
    localparam logic [4:0] CLOCK_BYTES = 5'd7;

    typedef enum logic [2:0] {
        SEQ_IDLE       = 3'd0,
        SEQ_WR_ADDR_LO = 3'd1,
        SEQ_WR_ADDR_HI = 3'd2,
        SEQ_WR_DATA_LO = 3'd3,
        SEQ_WR_DATA_HI = 3'd4,
        SEQ_RD_ADDR_LO = 3'd5,
        SEQ_RD_ADDR_HI = 3'd6
    } seq_t;

    // tens = v*205 >> 11, exact for all 8-bit v
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  tens;
        logic [7:0]  ones;
        prod = 16'(v) * 16'd205;
        tens = {3'd0, prod[15:11]};
        ones = v - 8'(tens * 8'd10);
        return {tens[3:0], ones[3:0]};
    endfunction

endpackage

[src/security_pic_nvram_rtc_unit.sv]
// Security chip command port: latch, serial/clock reply buffer, nibble-serial NVRAM.
// Depends on spnr_pkg and spnr_ram.
// An input item is registered in the execute stage (e_valid_reg), then in the output register behind m_valid.
// s_ready stays low while an item waits in the execute stage, which holds it until the output is free or m_ready.
// Reset: control state clears; the NVRAM is zeroed by a sweep over every address, s_ready low.
module security_pic_nvram_rtc_unit #(
    parameter int NVRAM_DEPTH = spnr_pkg::SPNR_NVRAM_DEPTH,
    parameter int REPLY_DEPTH = spnr_pkg::SPNR_REPLY_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_write_value,
    input  logic [5:0]  s_rtc_seconds,
    input  logic [5:0]  s_rtc_minutes,
    input  logic [4:0]  s_rtc_hours,
    input  logic [2:0]  s_rtc_weekday,
    input  logic [4:0]  s_rtc_day,
    input  logic [3:0]  s_rtc_month,
    input  logic [7:0]  s_rtc_year,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_value,
    output logic        m_status_bit
);

    localparam int AW = $clog2(NVRAM_DEPTH);
    localparam int RW = $clog2(REPLY_DEPTH);
    localparam int CW = RW + 1;

    logic [63:0] serial_low_reg, serial_high_reg;
    logic [8*REPLY_DEPTH-1:0] serial_all;

    logic        clear_reg;
    logic [AW-1:0] clear_cnt_reg;

    logic        e_valid_reg;
    logic [1:0]  e_mode_reg;
    logic [7:0]  e_wval_reg;
    logic [5:0]  e_sec_reg, e_min_reg;
    logic [4:0]  e_hour_reg, e_day_reg;
    logic [2:0]  e_wday_reg;
    logic [3:0]  e_month_reg;
    logic [7:0]  e_year_reg;

    logic [10:0]   hold_latch_reg, hold_latch_next;
    spnr_pkg::seq_t seq_reg, seq_next;
    logic [CW-1:0] reply_index_reg, reply_index_next;
    logic [CW-1:0] reply_count_reg, reply_count_next;
    logic [7:0]    nvram_address_reg, nvram_address_next;
    logic [7:0]    reply_buffer_reg [REPLY_DEPTH];
    logic [7:0]    reply_buffer_next [REPLY_DEPTH];

    logic        m_valid_reg;
    logic [7:0]  m_read_value_reg, rv_next;
    logic        m_status_bit_reg, st_next;

    logic        s_fire, e_fire;
    logic [3:0]  nib, cmd;
    logic        exec_cmd, latch_busy, pending;
    logic        ram_we, ram_we_e;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_wdata_e, ram_rdata;
    logic [3:0]  s_nib;

    assign cfg_ready  = 1'b1;
    assign serial_all = {serial_high_reg, serial_low_reg};

    assign s_ready = ~clear_reg & ~e_valid_reg;
    assign s_fire  = s_valid & s_ready;
    assign e_fire  = e_valid_reg & (~m_valid_reg | m_ready);

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status_bit = m_status_bit_reg;

    // read address for the NVRAM: the current address, with the incoming high nibble in SEQ_RD_ADDR_HI
    assign s_nib = s_write_value[3:0];
    always_comb begin
        if (seq_reg == spnr_pkg::SEQ_RD_ADDR_HI) begin
            ram_raddr = AW'({nvram_address_reg[7:4] | s_nib, nvram_address_reg[3:0]});
        end else begin
            ram_raddr = nvram_address_reg[AW-1:0];
        end
    end

    assign ram_we    = clear_reg | (e_fire & ram_we_e);
    assign ram_waddr = clear_reg ? clear_cnt_reg : nvram_address_reg[AW-1:0];
    assign ram_wdata = clear_reg ? 8'd0 : ram_wdata_e;

    spnr_ram #(
        .WIDTH(8),
        .DEPTH(NVRAM_DEPTH)
    ) u_nvram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (s_fire),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign nib        = e_wval_reg[3:0];
    assign exec_cmd   = (e_mode_reg == spnr_pkg::MODE_WRITE) & e_wval_reg[4];
    assign latch_busy = |hold_latch_reg[10:8];
    assign pending    = reply_index_reg < reply_count_reg;

    always_comb begin
        case (seq_reg)
            spnr_pkg::SEQ_IDLE: cmd = nib;
            spnr_pkg::SEQ_WR_ADDR_LO, spnr_pkg::SEQ_WR_ADDR_HI,
            spnr_pkg::SEQ_WR_DATA_LO, spnr_pkg::SEQ_WR_DATA_HI: cmd = spnr_pkg::CMD_NV_WRITE;
            default: cmd = spnr_pkg::CMD_NV_READ;
        endcase
    end

    // sequence next state
    always_comb begin
        seq_next = seq_reg;
        if (exec_cmd) begin
            case (cmd)
                spnr_pkg::CMD_NV_WRITE: begin
                    case (seq_reg)
                        spnr_pkg::SEQ_IDLE:       seq_next = spnr_pkg::SEQ_WR_ADDR_LO;
                        spnr_pkg::SEQ_WR_ADDR_LO: seq_next = spnr_pkg::SEQ_WR_ADDR_HI;
                        spnr_pkg::SEQ_WR_ADDR_HI: seq_next = spnr_pkg::SEQ_WR_DATA_LO;
                        spnr_pkg::SEQ_WR_DATA_LO: seq_next = spnr_pkg::SEQ_WR_DATA_HI;
                        default:                  seq_next = spnr_pkg::SEQ_IDLE;
                    endcase
                end
                spnr_pkg::CMD_NV_READ: begin
                    case (seq_reg)
                        spnr_pkg::SEQ_IDLE:       seq_next = spnr_pkg::SEQ_RD_ADDR_LO;
                        spnr_pkg::SEQ_RD_ADDR_LO: seq_next = spnr_pkg::SEQ_RD_ADDR_HI;
                        default:                  seq_next = spnr_pkg::SEQ_IDLE;
                    endcase
                end
                default: seq_next = seq_reg;
            endcase
        end
    end

    // execute stage: latch, reply buffer, NVRAM write-back, read results
    always_comb begin
        hold_latch_next    = hold_latch_reg;
        reply_index_next   = reply_index_reg;
        reply_count_next   = reply_count_reg;
        nvram_address_next = nvram_address_reg;
        reply_buffer_next  = reply_buffer_reg;
        ram_we_e    = 1'b0;
        ram_wdata_e = 8'd0;
        rv_next     = 8'd0;
        st_next     = 1'b0;

        if (e_mode_reg == spnr_pkg::MODE_WRITE) begin
            hold_latch_next = spnr_pkg::LATCH_WRITE | {7'd0, nib};
            if (exec_cmd) begin
                case (cmd)
                    spnr_pkg::CMD_REPLY: begin
                        if (pending) begin
                            hold_latch_next = spnr_pkg::LATCH_REPLY |
                                {3'd0, reply_buffer_reg[reply_index_reg[RW-1:0]]};
                            reply_index_next = reply_index_reg + CW'(1);
                        end
                    end
                    spnr_pkg::CMD_SERIAL: begin
                        for (int i = 0; i < REPLY_DEPTH; i++) begin
                            reply_buffer_next[i] = serial_all[i*8 +: 8];
                        end
                        reply_count_next = CW'(REPLY_DEPTH);
                        reply_index_next = '0;
                    end
                    spnr_pkg::CMD_CLOCK: begin
                        reply_buffer_next[0] = spnr_pkg::to_bcd({2'd0, e_sec_reg});
                        reply_buffer_next[1] = spnr_pkg::to_bcd({2'd0, e_min_reg});
                        reply_buffer_next[2] = spnr_pkg::to_bcd({3'd0, e_hour_reg});
                        reply_buffer_next[3] = spnr_pkg::to_bcd({5'd0, e_wday_reg} + 8'd1);
                        reply_buffer_next[4] = spnr_pkg::to_bcd({3'd0, e_day_reg});
                        reply_buffer_next[5] = spnr_pkg::to_bcd({4'd0, e_month_reg} + 8'd1);
                        reply_buffer_next[6] = spnr_pkg::to_bcd(e_year_reg - spnr_pkg::YEAR_BASE);
                        reply_count_next = CW'(spnr_pkg::CLOCK_BYTES);
                        reply_index_next = '0;
                    end
                    spnr_pkg::CMD_NV_WRITE: begin
                        case (seq_reg)
                            spnr_pkg::SEQ_WR_ADDR_LO: nvram_address_next = {4'd0, nib};
                            spnr_pkg::SEQ_WR_ADDR_HI: begin
                                nvram_address_next = nvram_address_reg | {nib, 4'd0};
                            end
                            spnr_pkg::SEQ_WR_DATA_LO: begin
                                ram_we_e    = 1'b1;
                                ram_wdata_e = {4'd0, nib};
                            end
                            spnr_pkg::SEQ_WR_DATA_HI: begin
                                ram_we_e    = 1'b1;
                                ram_wdata_e = ram_rdata | {nib, 4'd0};
                            end
                            default: ;
                        endcase
                    end
                    spnr_pkg::CMD_NV_READ: begin
                        case (seq_reg)
                            spnr_pkg::SEQ_IDLE: ;
                            spnr_pkg::SEQ_RD_ADDR_LO: nvram_address_next = {4'd0, nib};
                            default: begin
                                nvram_address_next   = nvram_address_reg | {nib, 4'd0};
                                reply_buffer_next[0] = ram_rdata;
                                reply_count_next     = CW'(1);
                                reply_index_next     = '0;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
        end else begin
            if (e_mode_reg == spnr_pkg::MODE_DATA || e_mode_reg == spnr_pkg::MODE_BOTH) begin
                if (latch_busy) begin
                    rv_next = hold_latch_reg[7:0];
                end else if (pending) begin
                    rv_next = 8'hFF;
                end
            end
            if (e_mode_reg == spnr_pkg::MODE_STATUS || e_mode_reg == spnr_pkg::MODE_BOTH) begin
                if (latch_busy) begin
                    hold_latch_next = hold_latch_reg - spnr_pkg::LATCH_TICK;
                    st_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serial_low_reg    <= '0;
            serial_high_reg   <= '0;
            clear_reg         <= 1'b1;
            clear_cnt_reg     <= '0;
            e_valid_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            hold_latch_reg    <= '0;
            seq_reg           <= spnr_pkg::SEQ_IDLE;
            reply_index_reg   <= '0;
            reply_count_reg   <= '0;
            nvram_address_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    spnr_pkg::CFG_SERIAL_LOW:  serial_low_reg  <= cfg_data;
                    spnr_pkg::CFG_SERIAL_HIGH: serial_high_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (clear_reg) begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
                if (clear_cnt_reg == AW'(NVRAM_DEPTH - 1)) begin
                    clear_reg <= 1'b0;
                end
            end
            if (s_fire) begin
                e_valid_reg <= 1'b1;
            end else if (e_fire) begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire) begin
                m_valid_reg       <= 1'b1;
                hold_latch_reg    <= hold_latch_next;
                seq_reg           <= seq_next;
                reply_index_reg   <= reply_index_next;
                reply_count_reg   <= reply_count_next;
                nvram_address_reg <= nvram_address_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            e_mode_reg  <= s_mode;
            e_wval_reg  <= s_write_value;
            e_sec_reg   <= s_rtc_seconds;
            e_min_reg   <= s_rtc_minutes;
            e_hour_reg  <= s_rtc_hours;
            e_wday_reg  <= s_rtc_weekday;
            e_day_reg   <= s_rtc_day;
            e_month_reg <= s_rtc_month;
            e_year_reg  <= s_rtc_year;
        end
        if (e_fire) begin
            m_read_value_reg  <= rv_next;
            m_status_bit_reg  <= st_next;
            reply_buffer_reg  <= reply_buffer_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> clear_reg && !e_valid_reg)
        else $error("reset did not start NVRAM clear");

    a_exec_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        e_fire |=> m_valid)
        else $error("executed item produced no result");

    a_ram_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> clear_reg || (e_valid_reg && e_mode_reg == spnr_pkg::MODE_WRITE))
        else $error("NVRAM written outside clear or write command");

    a_write_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        e_fire && e_mode_reg == spnr_pkg::MODE_WRITE |=> m_read_value == 8'd0 && !m_status_bit)
        else $error("write produced nonzero read result");

endmodule

[src/spnr_ram.sv]
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module spnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
